// ===== rtl/core/saac_pkg.sv =====
// Shared types, constants and helper functions for the stepper angle controller.
`timescale 1ns / 1ps
`default_nettype none
package saac_pkg;

    localparam int POSITION_WIDTH   = 16;
    localparam int TICK_COUNT_WIDTH = 20;

    // Configuration field widths
    localparam int SPR_W      = 16;
    localparam int DBT_W      = 20;
    localparam int DEG_CFG_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Payload widths
    localparam int CMD_W      = 2;
    localparam int IN_ANGLE_W = 16;
    localparam int ANGLE_W    = 9;

    localparam int DEG_FULL = 360;
    localparam int DEG_HALF = 180;
    // Offset-binary input plus this bias is congruent to the signed angle mod 360
    localparam int NORM_BIAS = DEG_FULL - ((2 ** (IN_ANGLE_W - 1)) % DEG_FULL);

    // Serial divider widths: sized so the dividend holds s*720 + r and the divisor holds 2r
    localparam int DVD_W = POSITION_WIDTH + 10;
    localparam int DVS_W = POSITION_WIDTH + 1;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam int DBT_CMP_W = (TICK_COUNT_WIDTH > DBT_W) ? TICK_COUNT_WIDTH : DBT_W;

    // Reset values of the registers
    localparam int SPR_RESET      = 3200;
    localparam int DBT_RESET      = 1200;
    localparam int MINCHG_RESET   = 2;
    localparam int DEADBAND_RESET = 1;
    localparam int HOLD_RESET     = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEPS_PER_REV = 3'd0,
        REG_DEBOUNCE      = 3'd1,
        REG_MIN_CHANGE    = 3'd2,
        REG_DEADBAND      = 3'd3,
        REG_HOLD          = 3'd4
    } saac_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_ANGLE = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NOP   = 2'd3
    } saac_cmd_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } saac_dir_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TK_MOD_GO,
        S_TK_MOD,
        S_SNAP_GO,
        S_SNAP,
        S_NORM_GO,
        S_NORM,
        S_TDEG_MOD_GO,
        S_TDEG_MOD,
        S_TDEG_ANG_GO,
        S_TDEG_ANG,
        S_TGT_GO,
        S_TGT,
        S_CUR_GO,
        S_CUR,
        S_REP_MOD_GO,
        S_REP_MOD,
        S_REP_ANG_GO,
        S_REP_ANG,
        S_DONE
    } saac_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]             command;
        logic signed [IN_ANGLE_W-1:0] target_angle;
    } saac_in_t;

    typedef struct packed {
        logic               pulse_level;
        logic               direction_pin;
        logic               driver_enable;
        logic [ANGLE_W-1:0] angle_deg;
        logic               moving;
        logic               command_taken;
    } saac_out_t;

    typedef struct packed {
        logic [SPR_W-1:0]     rev_steps;
        logic [DBT_W-1:0]     debounce_ticks;
        logic [DEG_CFG_W-1:0] min_change_deg;
        logic [DEG_CFG_W-1:0] deadband_deg;
        logic                 keep_enable;
    } saac_cfg_t;

    // Shortest distance between two angles on the circle
    function automatic logic [ANGLE_W-1:0] circ_diff(input logic [ANGLE_W-1:0] a,
                                                     input logic [ANGLE_W-1:0] b);
        logic [ANGLE_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d > ANGLE_W'(DEG_HALF)) ? (ANGLE_W'(DEG_FULL) - d) : d;
    endfunction

    // Fold a rounded angle of exactly 360 back to 0
    function automatic logic [ANGLE_W-1:0] wrap_deg(input logic [ANGLE_W-1:0] q);
        return (q >= ANGLE_W'(DEG_FULL)) ? (q - ANGLE_W'(DEG_FULL)) : q;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stepper_absolute_angle_controller_core.sv =====
// Top level of the stepper absolute-angle controller: registers, handshakes, result register.
`timescale 1ns / 1ps
`default_nettype none
// Each item is a half-period tick, an angle command or a stop, and returns one result with the
// step, direction and enable levels, the rounded angle and the filter outcome. One item is in
// work at a time; all arithmetic runs through a single bit-serial divider that produces one
// quotient bit per cycle. A tick with no step needs two divisions, a tick that takes a step
// three or four, an angle command up to seven, a stop two like an idle tick. The result goes
// to an output register, so the next item is taken while the previous result still waits on
// m_ready.
module stepper_absolute_angle_controller_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [saac_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [saac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire saac_pkg::saac_in_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output saac_pkg::saac_out_t                  m_data
);
    import saac_pkg::*;

    saac_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (saac_reg_t'(cfg_addr))
                REG_STEPS_PER_REV: cfg_next.rev_steps      = cfg_wdata[SPR_W-1:0];
                REG_DEBOUNCE:      cfg_next.debounce_ticks = cfg_wdata[DBT_W-1:0];
                REG_MIN_CHANGE:    cfg_next.min_change_deg = cfg_wdata[DEG_CFG_W-1:0];
                REG_DEADBAND:      cfg_next.deadband_deg   = cfg_wdata[DEG_CFG_W-1:0];
                REG_HOLD:          cfg_next.keep_enable    = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rev_steps      <= SPR_W'(SPR_RESET);
            cfg_reg.debounce_ticks <= DBT_W'(DBT_RESET);
            cfg_reg.min_change_deg <= DEG_CFG_W'(MINCHG_RESET);
            cfg_reg.deadband_deg   <= DEG_CFG_W'(DEADBAND_RESET);
            cfg_reg.keep_enable    <= 1'(HOLD_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    logic      res_valid;
    logic      res_ready;
    saac_out_t res;

    saac_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (s_valid),
        .item       (s_data),
        .item_ready (s_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Result register: load when empty or being drained
    logic      m_valid_reg, m_valid_next;
    saac_out_t m_data_reg, m_data_next;

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/saac_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module saac_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [saac_pkg::DVD_W-1:0]  dividend,
    input  wire logic [saac_pkg::DVS_W-1:0]  divisor,
    output logic                             done,
    output logic [saac_pkg::DVD_W-1:0]       quotient,
    output logic [saac_pkg::DVS_W-1:0]       remainder
);
    import saac_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;

    logic [DVS_W:0] trial;
    logic           fits;

    // Shift the next dividend bit into the partial remainder and try the subtract
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_below_dvs: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    a_last_bit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && cnt_reg == DIV_CNT_W'(1)) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last bit");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/saac_ctrl.sv =====
// Item sequencer and motion state for the stepper controller, built around one serial divider.
`timescale 1ns / 1ps
`default_nettype none
module saac_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire saac_pkg::saac_cfg_t cfg,
    input  wire logic                item_valid,
    input  wire saac_pkg::saac_in_t  item,
    output logic                     item_ready,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output saac_pkg::saac_out_t      res
);
    import saac_pkg::*;

    localparam int POS_W = POSITION_WIDTH;
    localparam int TCK_W = TICK_COUNT_WIDTH;

    saac_state_t state_reg, state_next;

    // Architectural state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   tpos_reg, tpos_next;
    logic               tv_reg, tv_next;
    logic [POS_W-1:0]   steps_reg, steps_next;
    saac_dir_t          dir_reg, dir_next;
    logic               pulse_reg, pulse_next;
    logic               en_reg, en_next;
    logic [ANGLE_W-1:0] last_reg, last_next;
    logic               lav_reg, lav_next;
    logic [TCK_W-1:0]   tsc_reg, tsc_next;
    logic               taken_reg, taken_next;

    // Per-item working registers
    logic [IN_ANGLE_W-1:0] ang_reg, ang_next;
    logic [ANGLE_W-1:0]    d_reg, d_next;
    logic [POS_W-1:0]      s_reg, s_next;
    logic [POS_W-1:0]      ntgt_reg, ntgt_next;
    logic [ANGLE_W-1:0]    angle_reg, angle_next;

    // Divider hookup
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;

    saac_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Effective revolution length
    logic [SPR_W+POS_W-1:0] spr_ext;
    logic [POS_W-1:0]       rev_raw;
    logic [POS_W-1:0]       rev;

    assign spr_ext = {{POS_W{1'b0}}, cfg.rev_steps};
    assign rev_raw = spr_ext[POS_W-1:0];
    assign rev     = (rev_raw < POS_W'(2)) ? POS_W'(2) : rev_raw;

    // Shared branch conditions
    saac_cmd_t          in_cmd;
    logic               tick_halt;
    logic               debounce_ok;
    logic [ANGLE_W-1:0] d_new;
    logic               minchg_fail;
    logic [ANGLE_W-1:0] q_deg;
    logic               in_band;
    logic [POS_W-1:0]   q_pos;
    logic               same_tgt;
    logic [POS_W-1:0]   r_pos;
    logic               moving;

    assign in_cmd      = saac_cmd_t'(item.command);
    assign tick_halt   = (dir_reg == DIR_STOP) || (steps_reg == '0);
    assign debounce_ok = (DBT_CMP_W'(tsc_reg) >= DBT_CMP_W'(cfg.debounce_ticks));
    assign d_new       = div_rem[ANGLE_W-1:0];
    assign minchg_fail = lav_reg &&
                         (circ_diff(d_new, last_reg) < ANGLE_W'(cfg.min_change_deg));
    assign q_deg       = wrap_deg(div_quo[ANGLE_W-1:0]);
    assign in_band     = (circ_diff(d_reg, q_deg) <= ANGLE_W'(cfg.deadband_deg));
    assign q_pos       = div_quo[POS_W-1:0];
    assign same_tgt    = tv_reg && (tpos_reg == q_pos) && (steps_reg != '0);
    assign r_pos       = div_rem[POS_W-1:0];
    assign moving      = (dir_reg != DIR_STOP) && (steps_reg != '0);

    // One step around the circle from the reduced position
    logic [POS_W:0]   p_inc;
    logic [POS_W-1:0] step_pos;

    assign p_inc = {1'b0, r_pos} + 1'b1;

    always_comb begin
        case (dir_reg)
            DIR_CW:  step_pos = (p_inc == {1'b0, rev}) ? '0 : p_inc[POS_W-1:0];
            DIR_CCW: step_pos = (r_pos == '0) ? (rev - 1'b1) : (r_pos - 1'b1);
            default: step_pos = r_pos;
        endcase
    end

    // Shortest signed path from the reduced position to the new target
    logic signed [POS_W+1:0] diff0, diff1, diff2, half_s, rev_s, diff_abs;

    assign half_s   = $signed({3'b000, rev[POS_W-1:1]});
    assign rev_s    = $signed({2'b00, rev});
    assign diff0    = $signed({2'b00, ntgt_reg}) - $signed({2'b00, r_pos});
    assign diff1    = (diff0 > half_s) ? (diff0 - rev_s) : diff0;
    assign diff2    = (diff1 < -half_s) ? (diff1 + rev_s) : diff1;
    assign diff_abs = diff2[POS_W+1] ? -diff2 : diff2;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    case (in_cmd)
                        CMD_TICK:  state_next = (tick_halt || !pulse_reg) ? S_REP_MOD_GO
                                                                          : S_TK_MOD_GO;
                        CMD_ANGLE: state_next = S_NORM_GO;
                        default:   state_next = S_REP_MOD_GO;
                    endcase
                end
            end
            S_TK_MOD_GO: state_next = S_TK_MOD;
            S_TK_MOD: begin
                if (div_done) begin
                    state_next = (steps_reg == '0 && tv_reg) ? S_SNAP_GO : S_REP_MOD_GO;
                end
            end
            S_SNAP_GO: state_next = S_SNAP;
            S_SNAP: begin
                if (div_done) begin
                    state_next = S_REP_MOD_GO;
                end
            end
            S_NORM_GO: state_next = S_NORM;
            S_NORM: begin
                if (div_done) begin
                    if (!debounce_ok || minchg_fail) begin
                        state_next = S_REP_MOD_GO;
                    end else if (tv_reg) begin
                        state_next = S_TDEG_MOD_GO;
                    end else begin
                        state_next = S_TGT_GO;
                    end
                end
            end
            S_TDEG_MOD_GO: state_next = S_TDEG_MOD;
            S_TDEG_MOD: begin
                if (div_done) begin
                    state_next = S_TDEG_ANG_GO;
                end
            end
            S_TDEG_ANG_GO: state_next = S_TDEG_ANG;
            S_TDEG_ANG: begin
                if (div_done) begin
                    state_next = in_band ? S_REP_MOD_GO : S_TGT_GO;
                end
            end
            S_TGT_GO: state_next = S_TGT;
            S_TGT: begin
                if (div_done) begin
                    state_next = same_tgt ? S_REP_MOD_GO : S_CUR_GO;
                end
            end
            S_CUR_GO: state_next = S_CUR;
            S_CUR: begin
                if (div_done) begin
                    state_next = S_REP_MOD_GO;
                end
            end
            S_REP_MOD_GO: state_next = S_REP_MOD;
            S_REP_MOD: begin
                if (div_done) begin
                    state_next = S_REP_ANG_GO;
                end
            end
            S_REP_ANG_GO: state_next = S_REP_ANG;
            S_REP_ANG: begin
                if (div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath updates and divider launches
    always_comb begin
        pos_next   = pos_reg;
        tpos_next  = tpos_reg;
        tv_next    = tv_reg;
        steps_next = steps_reg;
        dir_next   = dir_reg;
        pulse_next = pulse_reg;
        en_next    = en_reg;
        last_next  = last_reg;
        lav_next   = lav_reg;
        tsc_next   = tsc_reg;
        taken_next = taken_reg;
        ang_next   = ang_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        ntgt_next  = ntgt_reg;
        angle_next = angle_reg;
        div_start  = 1'b0;
        div_dvd    = DVD_W'(pos_reg);
        div_dvs    = DVS_W'(rev);
        case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    taken_next = 1'b0;
                    ang_next   = {~item.target_angle[IN_ANGLE_W-1],
                                  item.target_angle[IN_ANGLE_W-2:0]};
                    case (in_cmd)
                        CMD_TICK: begin
                            if (!(&tsc_reg)) begin
                                tsc_next = tsc_reg + 1'b1;
                            end
                            if (tick_halt) begin
                                pulse_next = 1'b0;
                            end else if (!pulse_reg) begin
                                pulse_next = 1'b1;
                            end else begin
                                // falling edge: take the step
                                pulse_next = 1'b0;
                                steps_next = steps_reg - 1'b1;
                            end
                        end
                        CMD_STOP: begin
                            dir_next   = DIR_STOP;
                            steps_next = '0;
                            en_next    = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_TK_MOD_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(pos_reg);
                div_dvs   = DVS_W'(rev);
            end
            S_TK_MOD: begin
                if (div_done) begin
                    pos_next = step_pos;
                    if (steps_reg == '0) begin
                        dir_next = DIR_STOP;
                        if (!cfg.keep_enable) begin
                            en_next = 1'b0;
                        end
                    end
                end
            end
            S_SNAP_GO, S_TDEG_MOD_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(tpos_reg);
                div_dvs   = DVS_W'(rev);
            end
            S_SNAP: begin
                if (div_done) begin
                    pos_next = r_pos;
                end
            end
            S_NORM_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(ang_reg) + DVD_W'(NORM_BIAS);
                div_dvs   = DVS_W'(DEG_FULL);
            end
            S_NORM: begin
                if (div_done) begin
                    d_next = d_new;
                end
            end
            S_TDEG_MOD, S_REP_MOD: begin
                if (div_done) begin
                    s_next = r_pos;
                end
            end
            S_TDEG_ANG_GO, S_REP_ANG_GO: begin
                // rounded angle: (s*720 + r) / 2r
                div_start = 1'b1;
                div_dvd   = DVD_W'(s_reg) * DVD_W'(2 * DEG_FULL) + DVD_W'(rev);
                div_dvs   = {rev, 1'b0};
            end
            S_TDEG_ANG: begin
                if (div_done && in_band) begin
                    last_next  = q_deg;
                    lav_next   = 1'b1;
                    tsc_next   = '0;
                    taken_next = 1'b1;
                end
            end
            S_TGT_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(d_reg) * DVD_W'(rev);
                div_dvs   = DVS_W'(DEG_FULL);
            end
            S_TGT: begin
                if (div_done) begin
                    ntgt_next  = q_pos;
                    last_next  = d_reg;
                    lav_next   = 1'b1;
                    tsc_next   = '0;
                    taken_next = 1'b1;
                end
            end
            S_CUR_GO, S_REP_MOD_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(pos_reg);
                div_dvs   = DVS_W'(rev);
            end
            S_CUR: begin
                if (div_done) begin
                    tpos_next = ntgt_reg;
                    tv_next   = 1'b1;
                    if (diff2 != '0) begin
                        dir_next   = diff2[POS_W+1] ? DIR_CCW : DIR_CW;
                        steps_next = diff_abs[POS_W-1:0];
                        en_next    = 1'b1;
                    end
                end
            end
            S_REP_ANG: begin
                if (div_done) begin
                    angle_next = q_deg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            tpos_reg  <= '0;
            tv_reg    <= 1'b0;
            steps_reg <= '0;
            dir_reg   <= DIR_STOP;
            pulse_reg <= 1'b0;
            en_reg    <= 1'b0;
            last_reg  <= '0;
            lav_reg   <= 1'b0;
            tsc_reg   <= '0;
            taken_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            tpos_reg  <= tpos_next;
            tv_reg    <= tv_next;
            steps_reg <= steps_next;
            dir_reg   <= dir_next;
            pulse_reg <= pulse_next;
            en_reg    <= en_next;
            last_reg  <= last_next;
            lav_reg   <= lav_next;
            tsc_reg   <= tsc_next;
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        ang_reg   <= ang_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        ntgt_reg  <= ntgt_next;
        angle_reg <= angle_next;
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);

    always_comb begin
        res.pulse_level   = pulse_reg;
        res.direction_pin = (dir_reg != DIR_CW);
        res.driver_enable = en_reg;
        res.angle_deg     = angle_reg;
        res.moving        = moving;
        res.command_taken = taken_reg;
    end

`ifndef ASSERT_OFF
    a_moving_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        moving |-> en_reg)
        else $error("moving with driver disabled");

    a_last_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lav_reg |-> (last_reg < ANGLE_W'(DEG_FULL)))
        else $error("accepted angle out of range");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_TK_MOD || state_reg == S_SNAP ||
                      state_reg == S_NORM || state_reg == S_TDEG_MOD ||
                      state_reg == S_TDEG_ANG || state_reg == S_TGT ||
                      state_reg == S_CUR || state_reg == S_REP_MOD ||
                      state_reg == S_REP_ANG))
        else $error("divider result arrived outside a wait state");
`endif

endmodule
`default_nettype wire

// ===== tb/saac_checker.sv =====
// Checker for the stepper angle controller: predicts each result and compares it.
`timescale 1ns / 1ps
module saac_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [saac_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [saac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  saac_pkg::saac_in_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  saac_pkg::saac_out_t             m_data,
    output int                              fail_count,
    output int                              outstanding,
    output int                              results_checked,
    output int                              commands_taken
);
    import saac_pkg::*;

    localparam longint unsigned TICK_LIMIT = (64'd1 << TICK_COUNT_WIDTH) - 1;

    // register copies
    logic [SPR_W-1:0]     cfg_rev_steps;
    logic [DBT_W-1:0]     cfg_debounce;
    logic [DEG_CFG_W-1:0] cfg_min_change;
    logic [DEG_CFG_W-1:0] cfg_deadband;
    logic                 cfg_hold;

    // controller state
    logic [POSITION_WIDTH-1:0]   ctl_position;
    logic [POSITION_WIDTH-1:0]   ctl_target;
    logic                        ctl_target_valid;
    logic [POSITION_WIDTH-1:0]   ctl_steps_left;
    saac_dir_t                   ctl_dir;
    logic                        ctl_pulse;
    logic                        ctl_enabled;
    logic [ANGLE_W-1:0]          ctl_last_angle;
    logic                        ctl_last_valid;
    logic [TICK_COUNT_WIDTH-1:0] ctl_ticks;

    saac_out_t status_due[$];
    saac_out_t due;

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_checked, name, got, want));
    endtask

    function automatic int unsigned active_rev();
        return (cfg_rev_steps < 2) ? 2 : cfg_rev_steps;
    endfunction

    function automatic int unsigned round_angle(input int unsigned steps);
        longint unsigned r, s, a;
        r = active_rev();
        s = steps % r;
        a = (s * (2 * DEG_FULL) + r) / (2 * r);
        if (a >= DEG_FULL) a -= DEG_FULL;
        return 32'(a);
    endfunction

    function automatic int unsigned steps_for_deg(input int unsigned deg);
        longint unsigned prod;
        prod = longint'(deg) * active_rev();
        return 32'(prod / DEG_FULL);
    endfunction

    function automatic int unsigned arc_gap(input int unsigned a, input int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return (d > DEG_HALF) ? DEG_FULL - d : d;
    endfunction

    task automatic reset_controller();
        cfg_rev_steps     = SPR_W'(SPR_RESET);
        cfg_debounce      = DBT_W'(DBT_RESET);
        cfg_min_change    = DEG_CFG_W'(MINCHG_RESET);
        cfg_deadband      = DEG_CFG_W'(DEADBAND_RESET);
        cfg_hold          = 1'(HOLD_RESET);
        ctl_position      = '0;
        ctl_target        = '0;
        ctl_target_valid  = 1'b0;
        ctl_steps_left    = '0;
        ctl_dir           = DIR_STOP;
        ctl_pulse         = 1'b0;
        ctl_enabled       = 1'b0;
        ctl_last_angle    = '0;
        ctl_last_valid    = 1'b0;
        ctl_ticks         = '0;
    endtask

    task automatic half_period_tick();
        int unsigned r, p;
        if (ctl_ticks < TICK_LIMIT) ctl_ticks++;
        if (ctl_dir == DIR_STOP || ctl_steps_left == 0) begin
            ctl_pulse = 1'b0;
        end else if (!ctl_pulse) begin
            ctl_pulse = 1'b1;
        end else begin
            // falling edge of the step line: take the step
            ctl_pulse = 1'b0;
            ctl_steps_left--;
            r = active_rev();
            p = ctl_position % r;
            if (ctl_dir == DIR_CW) p = (p + 1 == r) ? 0 : p + 1;
            else if (ctl_dir == DIR_CCW) p = (p == 0) ? r - 1 : p - 1;
            ctl_position = POSITION_WIDTH'(p);
            if (ctl_steps_left == 0) begin
                ctl_dir = DIR_STOP;
                if (ctl_target_valid) ctl_position = POSITION_WIDTH'(ctl_target % r);
                if (!cfg_hold) ctl_enabled = 1'b0;
            end
        end
    endtask

    function automatic bit take_angle(input logic signed [IN_ANGLE_W-1:0] raw);
        int v, diff, half;
        int unsigned d, tgt, r, cur, tdeg;
        v = int'(raw);
        v = v % DEG_FULL;
        if (v < 0) v += DEG_FULL;
        d = v;
        if (ctl_ticks < cfg_debounce) return 1'b0;
        if (ctl_last_valid && arc_gap(d, ctl_last_angle) < cfg_min_change) return 1'b0;
        if (ctl_target_valid) begin
            tdeg = round_angle(ctl_target);
            if (arc_gap(d, tdeg) <= cfg_deadband) begin
                // same as the current target: refresh the filters only
                ctl_last_angle = ANGLE_W'(tdeg);
                ctl_last_valid = 1'b1;
                ctl_ticks      = '0;
                return 1'b1;
            end
        end
        tgt = steps_for_deg(d);
        ctl_last_angle = ANGLE_W'(d);
        ctl_last_valid = 1'b1;
        ctl_ticks      = '0;
        if (ctl_target_valid && ctl_target == tgt && ctl_steps_left > 0) return 1'b1;
        r    = active_rev();
        cur  = ctl_position % r;
        diff = int'(tgt) - int'(cur);
        half = int'(r / 2);
        if (diff > half) diff -= int'(r);
        if (diff < -half) diff += int'(r);
        ctl_target       = POSITION_WIDTH'(tgt);
        ctl_target_valid = 1'b1;
        if (diff == 0) return 1'b1;
        ctl_dir        = (diff > 0) ? DIR_CW : DIR_CCW;
        ctl_steps_left = POSITION_WIDTH'((diff > 0) ? diff : -diff);
        ctl_enabled    = 1'b1;
        return 1'b1;
    endfunction

    task automatic advance_controller(input saac_in_t item, output saac_out_t res);
        bit taken;
        taken = 1'b0;
        case (item.command)
            CMD_TICK:  half_period_tick();
            CMD_ANGLE: taken = take_angle(item.target_angle);
            CMD_STOP: begin
                ctl_dir        = DIR_STOP;
                ctl_steps_left = '0;
                ctl_enabled    = 1'b0;
            end
            default: ;
        endcase
        res.pulse_level   = ctl_pulse;
        res.direction_pin = (ctl_dir == DIR_CW) ? 1'b0 : 1'b1;
        res.driver_enable = ctl_enabled;
        res.angle_deg     = ANGLE_W'(round_angle(ctl_position));
        res.moving        = (ctl_dir != DIR_STOP) && (ctl_steps_left > 0);
        res.command_taken = taken;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_controller();
            status_due.delete();
        end else begin
            if (cfg_we) begin
                case (saac_reg_t'(cfg_addr))
                    REG_STEPS_PER_REV: cfg_rev_steps  = cfg_wdata[SPR_W-1:0];
                    REG_DEBOUNCE:      cfg_debounce   = cfg_wdata[DBT_W-1:0];
                    REG_MIN_CHANGE:    cfg_min_change = cfg_wdata[DEG_CFG_W-1:0];
                    REG_DEADBAND:      cfg_deadband   = cfg_wdata[DEG_CFG_W-1:0];
                    REG_HOLD:          cfg_hold       = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_controller(s_data, due);
                if (due.command_taken) commands_taken++;
                status_due.push_back(due);
            end
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    report_error("result arrived with nothing expected");
                end else begin
                    due = status_due.pop_front();
                    check_field("pulse_level",   m_data.pulse_level,   due.pulse_level);
                    check_field("direction_pin", m_data.direction_pin, due.direction_pin);
                    check_field("driver_enable", m_data.driver_enable, due.driver_enable);
                    check_field("angle_deg",     m_data.angle_deg,     due.angle_deg);
                    check_field("moving",        m_data.moving,        due.moving);
                    check_field("command_taken", m_data.command_taken, due.command_taken);
                    results_checked++;
                end
            end
        end
        outstanding = status_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the stepper angle controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import saac_pkg::*;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 180;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    saac_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    saac_out_t             m_data;

    int fail_count, outstanding, results_checked, commands_taken;
    int send_idle_pct = 22;
    int recv_idle_pct = 72;
    int items_sent    = 0;
    int last_angle_sent = 0;

    stepper_absolute_angle_controller_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    saac_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .commands_taken  (commands_taken)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #20ms;
        $display("Timeout: run did not complete");
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input saac_cmd_t cmd, input int angle);
        saac_in_t item;
        item.command      = cmd;
        item.target_angle = IN_ANGLE_W'(angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // hold the sender off until every result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input saac_reg_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
    endtask

    task automatic program_settings(input int unsigned spr, input int unsigned dbt,
                                    input int unsigned minc, input int unsigned dead,
                                    input int unsigned hold);
        write_reg(REG_STEPS_PER_REV, spr);
        write_reg(REG_DEBOUNCE, dbt);
        write_reg(REG_MIN_CHANGE, minc);
        write_reg(REG_DEADBAND, dead);
        write_reg(REG_HOLD, hold);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        int sel, angle;
        sel   = $urandom_range(99);
        angle = $urandom_range(65535);
        if (sel < 68) begin
            send_item(CMD_TICK, angle);
        end else if (sel < 90) begin
            case ($urandom_range(3))
                0: ;
                1: angle = last_angle_sent + $urandom_range(8) - 4;
                2: angle = last_angle_sent + DEG_FULL * ($urandom_range(40) - 20);
                default: angle = last_angle_sent + DEG_HALF;
            endcase
            angle = int'(IN_ANGLE_W'(angle));
            last_angle_sent = $signed(IN_ANGLE_W'(angle));
            send_item(CMD_ANGLE, angle);
        end else if (sel < 95) begin
            send_item(CMD_STOP, angle);
        end else begin
            send_item(CMD_NOP, angle);
        end
    endtask

    initial begin
        int unsigned spr, dbt, minc, dead, hold;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: debounce rejects, unused code, tick and stop
        send_item(CMD_ANGLE, 90);
        send_item(CMD_NOP, -32768);
        send_item(CMD_TICK, 32767);
        send_item(CMD_STOP, 0);
        wait_idle();

        // revolution below two, no filtering, torque released at the end
        program_settings(1, 0, 0, 0, 0);
        send_item(CMD_ANGLE, 32767);
        send_item(CMD_ANGLE, -32768);
        send_item(CMD_TICK, 0);
        send_item(CMD_TICK, 0);
        send_item(CMD_STOP, 0);
        wait_idle();

        // new revolution; retarget mid-move, stop, then an angle on the current target
        program_settings(8, 0, 0, 0, 1);
        send_item(CMD_ANGLE, 180);
        send_item(CMD_TICK, 0);
        send_item(CMD_TICK, 0);
        send_item(CMD_ANGLE, 90);
        repeat (4) send_item(CMD_TICK, 0);
        send_item(CMD_ANGLE, 0);
        send_item(CMD_TICK, 0);
        send_item(CMD_STOP, 0);
        send_item(CMD_TICK, 0);
        send_item(CMD_ANGLE, 720);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin spr = 2;     dbt = 0;       minc = 0;   dead = 0;   hold = 0; end
                1: begin spr = 12;    dbt = 3;       minc = 2;   dead = 1;   hold = 1; end
                2: begin spr = 65535; dbt = 0;       minc = 0;   dead = 0;   hold = 1; end
                3: begin spr = 36;    dbt = 1048575; minc = 180; dead = 180; hold = 0; end
                4: begin spr = 200;   dbt = 2;       minc = 180; dead = 0;   hold = 0; end
                5: begin spr = 0;     dbt = 0;       minc = 5;   dead = 180; hold = 1; end
                6: begin
                    spr  = 2 * $urandom_range(1, 200);
                    dbt  = $urandom_range(4);
                    minc = $urandom_range(10);
                    dead = $urandom_range(10);
                    hold = $urandom_range(1);
                end
                7: begin spr = 3200;  dbt = 0;       minc = 2;   dead = 1;   hold = 1; end
                default: begin
                    spr  = 2 * $urandom_range(1, 32);
                    dbt  = 0;
                    minc = $urandom_range(3);
                    dead = $urandom_range(3);
                    hold = $urandom_range(1);
                end
            endcase
            program_settings(spr, dbt, minc, dead, hold);
            if (phase < 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 72;
            end else if (phase < 6) begin
                send_idle_pct = 72;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(149) == 0) wait_idle();
                send_random_item();
            end
        end

        wait_idle();
        repeat (250) @(posedge aclk);
        $display("Sent %0d items over %0d register settings; %0d results checked,",
                 items_sent, NUM_PHASES + 3, results_checked);
        $display("%0d angle commands taken, %0d mismatches", commands_taken, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/saac_pkg.sv
rtl/core/saac_div.sv
rtl/core/saac_ctrl.sv
rtl/core/stepper_absolute_angle_controller_core.sv
tb/saac_checker.sv
tb/testbench.sv
